// File: rtl/core/shs_pkg.sv
package shs_pkg;

   // Width of the running message bit counter; the padding carries it as the 64-bit length field.
   localparam int LenCntWidth = 64;

   // Byte position where the length field starts in the final block.
   localparam logic [5:0] LenPos = 6'd56;

   // First padding byte after the message.
   localparam logic [7:0] PadByte = 8'h80;

   // Initial chaining words.
   localparam logic [31:0] InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // Round constants.
   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // Controls for the message schedule window.
   typedef struct packed {
      logic       push;
      logic [7:0] push_data;
      logic       expand;
   } shs_sched_ctl_type;

   // Controls for the round datapath and chaining words.
   typedef struct packed {
      logic load_vars;
      logic do_round;
      logic add_chain;
      logic init_chain;
   } shs_round_ctl_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sig0(input logic [31:0] x);
      big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sig1(input logic [31:0] x);
      big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sig0(input logic [31:0] x);
      small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sig1(input logic [31:0] x);
      small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

// File: rtl/core/sha256_stream_hasher_unit.sv
// Absorb request: taken when idle; the 64th byte of a block starts the compression rounds
// and the chaining add in the single round unit, and no byte is taken until they are done.
// Finish request: padding bytes up to the block end, then the compression of one or two
// blocks, then eight digest words, one per cycle while the result side is ready.
// Synchronous active-high reset returns the chaining words to the initial values and clears
// the byte fill, bit counter and sequencer; the block is ready in the cycle after reset.
module sha256_stream_hasher_unit
   import shs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] op: 0 absorb, 1 finish
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast    // last_word
);

   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StPad  = 3'd1;
   localparam logic [2:0] StComp = 3'd2;
   localparam logic [2:0] StAdd  = 3'd3;
   localparam logic [2:0] StOut  = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [5:0]             fill_ff, fill_in;
   logic [LenCntWidth-1:0] bits_ff, bits_in;
   logic [5:0]             round_ff, round_in;
   logic                   sent80_ff, sent80_in;
   logic                   extra_ff, extra_in;
   logic                   fin_ff, fin_in;
   logic [2:0]             word_ff, word_in;

   logic              req_fire;
   logic              rsp_fire;
   logic              absorb;
   logic              finish;
   logic              push;
   logic [63:0]       len64;
   logic [7:0]        len_byte;
   logic [7:0]        pad_byte;
   logic [31:0]       w_cur;
   logic [31:0]       digest_word;
   shs_sched_ctl_type sched_ctl;
   shs_round_ctl_type round_ctl;

   // Handshakes.
   assign req_tready = (state_ff == StIdle);
   assign req_fire   = req_tvalid && req_tready;
   assign absorb     = req_fire && !req_tuser;
   assign finish     = req_fire && req_tuser;
   assign rsp_tvalid = (state_ff == StOut);
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   // Padding byte: the marker first, then zeros, then the big-endian bit length.
   assign len64    = 64'(bits_ff);
   assign len_byte = len64[{~fill_ff[2:0], 3'b000} +: 8];
   always_comb begin
      if (!sent80_ff) begin
         pad_byte = PadByte;
      end else if ((fill_ff >= LenPos) && !extra_ff) begin
         pad_byte = len_byte;
      end else begin
         pad_byte = 8'h00;
      end
   end

   // Control to the schedule window and the round datapath.
   assign push                = absorb || (state_ff == StPad);
   assign sched_ctl.push      = push;
   assign sched_ctl.push_data = (state_ff == StPad) ? pad_byte : req_tdata;
   assign sched_ctl.expand    = (state_ff == StComp);
   assign round_ctl.load_vars  = push && (fill_ff == 6'd63);
   assign round_ctl.do_round   = (state_ff == StComp);
   assign round_ctl.add_chain  = (state_ff == StAdd);
   assign round_ctl.init_chain = rsp_fire && (word_ff == 3'd7);

   shs_sched u_sched (
      .clock (clock),
      .ctl   (sched_ctl),
      .w_cur (w_cur)
   );

   shs_round u_round (
      .clock       (clock),
      .reset       (reset),
      .ctl         (round_ctl),
      .round_idx   (round_ff),
      .w_cur       (w_cur),
      .word_sel    (word_ff),
      .digest_word (digest_word)
   );

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      bits_in   = bits_ff;
      round_in  = round_ff;
      sent80_in = sent80_ff;
      extra_in  = extra_ff;
      fin_in    = fin_ff;
      word_in   = word_ff;
      unique case (state_ff)
         StIdle: begin
            if (absorb) begin
               fill_in = fill_ff + 6'd1;
               bits_in = bits_ff + LenCntWidth'(8);
               if (fill_ff == 6'd63) begin
                  state_in = StComp;
               end
            end else if (finish) begin
               state_in  = StPad;
               sent80_in = 1'b0;
               extra_in  = 1'b0;
               fin_in    = 1'b1;
            end
         end
         StPad: begin
            fill_in = fill_ff + 6'd1;
            if (!sent80_ff) begin
               sent80_in = 1'b1;
               extra_in  = (fill_ff >= LenPos);
            end
            if (fill_ff == 6'd63) begin
               state_in = StComp;
            end
         end
         StComp: begin
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = StAdd;
            end
         end
         StAdd: begin
            if (!fin_ff) begin
               state_in = StIdle;
            end else if (extra_ff) begin
               extra_in = 1'b0;
               state_in = StPad;
            end else begin
               word_in  = 3'd0;
               state_in = StOut;
            end
         end
         StOut: begin
            if (rsp_fire) begin
               word_in = word_ff + 3'd1;
               if (word_ff == 3'd7) begin
                  state_in = StIdle;
                  fill_in  = 6'd0;
                  bits_in  = '0;
                  fin_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= StIdle;
         fill_ff   <= 6'd0;
         bits_ff   <= '0;
         round_ff  <= 6'd0;
         sent80_ff <= 1'b0;
         extra_ff  <= 1'b0;
         fin_ff    <= 1'b0;
         word_ff   <= 3'd0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         bits_ff   <= bits_in;
         round_ff  <= round_in;
         sent80_ff <= sent80_in;
         extra_ff  <= extra_in;
         fin_ff    <= fin_in;
         word_ff   <= word_in;
      end
   end

   // Result channel.
   assign rsp_tdata = digest_word;
   assign rsp_tuser = word_ff;
   assign rsp_tlast = (word_ff == 3'd7);

   // No request is taken while digest words are offered.
   a_no_req_during_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request accepted while digest is pending");

   // The last digest word leaves the block ready with a cleared message.
   a_clear_after_digest: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=>
         (req_tready && (fill_ff == 6'd0) && (bits_ff == '0)))
      else $error("state not cleared after digest");

   // Rounds advance one per cycle without a break.
   a_round_step: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == StComp) && (round_ff != 6'd63)) |=>
         ((state_ff == StComp) && (round_ff == $past(round_ff) + 6'd1)))
      else $error("round counter skipped");

   // Every compression starts on a block boundary.
   a_block_boundary: assert property (@(posedge clock) disable iff (reset)
      ((state_ff != StComp) && (state_in == StComp)) |=> (fill_ff == 6'd0))
      else $error("compression started on a partial block");

endmodule

// File: rtl/core/shs_sched.sv
module shs_sched
   import shs_pkg::*;
(
   input  logic              clock,
   input  shs_sched_ctl_type ctl,
   output logic [31:0]       w_cur
);

   logic [31:0] win_ff [16];
   logic [31:0] win_in [16];
   logic [31:0] new_w;

   // Next schedule word from the four fixed taps of the window.
   assign new_w = small_sig1(win_ff[14]) + win_ff[9] + small_sig0(win_ff[1]) + win_ff[0];

   // Bytes shift in big-endian while a block is gathered; words shift during rounds.
   always_comb begin
      win_in = win_ff;
      if (ctl.push) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = {win_ff[i][23:0], win_ff[i+1][31:24]};
         end
         win_in[15] = {win_ff[15][23:0], ctl.push_data};
      end else if (ctl.expand) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[15] = new_w;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   assign w_cur = win_ff[0];

endmodule

// File: rtl/core/shs_round.sv
module shs_round
   import shs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  shs_round_ctl_type ctl,
   input  logic [5:0]        round_idx,
   input  logic [31:0]       w_cur,
   input  logic [2:0]        word_sel,
   output logic [31:0]       digest_word
);

   logic [31:0] chain_ff [8];
   logic [31:0] chain_in [8];
   logic [31:0] vars_ff [8];
   logic [31:0] vars_in [8];
   logic [31:0] t1;
   logic [31:0] t2;
   logic [31:0] ch;
   logic [31:0] maj;

   // One compression round on the working variables a through h.
   assign ch  = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
   assign maj = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2]) ^
                (vars_ff[1] & vars_ff[2]);
   assign t1  = vars_ff[7] + big_sig1(vars_ff[4]) + ch + RoundK[round_idx] + w_cur;
   assign t2  = big_sig0(vars_ff[0]) + maj;

   always_comb begin
      vars_in = vars_ff;
      if (ctl.load_vars) begin
         vars_in = chain_ff;
      end else if (ctl.do_round) begin
         vars_in[7] = vars_ff[6];
         vars_in[6] = vars_ff[5];
         vars_in[5] = vars_ff[4];
         vars_in[4] = vars_ff[3] + t1;
         vars_in[3] = vars_ff[2];
         vars_in[2] = vars_ff[1];
         vars_in[1] = vars_ff[0];
         vars_in[0] = t1 + t2;
      end
   end

   // Chaining words take the block result, or return to the initial values after a digest.
   always_comb begin
      chain_in = chain_ff;
      if (ctl.init_chain) begin
         chain_in = InitHash;
      end else if (ctl.add_chain) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + vars_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= InitHash;
      end else begin
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      vars_ff <= vars_in;
   end

   assign digest_word = chain_ff[word_sel];

endmodule
